@@ sv/evr_pkg.sv @@
// shared constants and tables of the euler vector rotator
package evr_pkg;

  // defaults of the top level parameters
  localparam int VEC_WIDTH_DEF     = 24;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // number of tabled arctangent entries
  localparam int ATAN_ENTRIES = 24;

  // cordic datapath widths: angle accumulator, x/y lanes, q24 sine/cosine
  localparam int ZW = 34;
  localparam int XW = 33;
  localparam int CW = 28;

  // q30 constants
  localparam logic signed [ZW-1:0] Q30_PI      = ZW'(34'sh0C90FDAA2);
  localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(34'sh06487ED51);
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(33'sh026DD3B6A);

  // atan(2^-i) in q30, truncated
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0:       r = 32'h3243F6A8;
      1:       r = 32'h1DAC6705;
      2:       r = 32'h0FADBAFC;
      3:       r = 32'h07F56EA6;
      4:       r = 32'h03FEAB76;
      5:       r = 32'h01FFD55B;
      6:       r = 32'h00FFFAAA;
      7:       r = 32'h007FFF55;
      8:       r = 32'h003FFFEA;
      9:       r = 32'h001FFFFD;
      10:      r = 32'h000FFFFF;
      11:      r = 32'h0007FFFF;
      12:      r = 32'h0003FFFF;
      13:      r = 32'h0001FFFF;
      14:      r = 32'h0000FFFF;
      15:      r = 32'h00007FFF;
      16:      r = 32'h00003FFF;
      17:      r = 32'h00001FFF;
      18:      r = 32'h00000FFF;
      19:      r = 32'h000007FF;
      20:      r = 32'h000003FF;
      21:      r = 32'h000001FF;
      22:      r = 32'h000000FF;
      23:      r = 32'h0000007F;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/evr_fifo.sv @@
// small request queue with registered storage
module evr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW:0]  wp_q, wp_d, rp_q, rp_d;
  logic         do_push, do_pop;

  assign full_o  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
  assign empty_o = (wp_q == rp_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q[AW-1:0]];
  assign wp_d    = do_push ? wp_q + (AW+1)'(1) : wp_q;
  assign rp_d    = do_pop ? rp_q + (AW+1)'(1) : rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q[AW-1:0]] <= data_i;
    end
  end

endmodule

@@ sv/evr_front.sv @@
// front end: angle negation, scaling to q30 and quadrant fold
module evr_front #(
  parameter int ANGLE_WIDTH = evr_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          func_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_i,
  output logic signed [evr_pkg::ZW-1:0] z_o    [3],
  output logic                          flip_o [3]
);
  import evr_pkg::*;

  localparam int ZSH = 33 - ANGLE_WIDTH;

  logic signed [ANGLE_WIDTH-1:0] ang [3];

  assign ang[0] = yaw_i;
  assign ang[1] = roll_i;
  assign ang[2] = pitch_i;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [ZW-1:0] a, z;
    always_comb begin
      a = ZW'(ang[l]);
      if (func_i) begin
        a = -a;
      end
      z = a <<< ZSH;
      flip_o[l] = 1'b0;
      z_o[l]    = z;
      if (z > Q30_HALF_PI) begin
        z_o[l]    = z - Q30_PI;
        flip_o[l] = 1'b1;
      end else if (z < -Q30_HALF_PI) begin
        z_o[l]    = z + Q30_PI;
        flip_o[l] = 1'b1;
      end
    end
  end

endmodule

@@ sv/evr_cordic_stage.sv @@
// one registered cordic rotation stage
module evr_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [evr_pkg::XW-1:0] x_i,
  input  logic signed [evr_pkg::XW-1:0] y_i,
  input  logic signed [evr_pkg::ZW-1:0] z_i,
  input  logic                          flip_i,
  output logic signed [evr_pkg::XW-1:0] x_o,
  output logic signed [evr_pkg::XW-1:0] y_o,
  output logic signed [evr_pkg::ZW-1:0] z_o,
  output logic                          flip_o
);
  import evr_pkg::*;

  localparam logic signed [ZW-1:0] ATN = ZW'(atan_q30(IDX));

  logic signed [XW-1:0] dx, dy, x_d, y_d;
  logic signed [ZW-1:0] z_d;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      flip_o <= flip_i;
    end
  end

endmodule

@@ sv/evr_back.sv @@
// back end: cordic pipeline, three rotations and output saturation
module evr_back #(
  parameter int VEC_WIDTH     = evr_pkg::VEC_WIDTH_DEF,
  parameter int CORDIC_STAGES = evr_pkg::CORDIC_STAGES_DEF,
  parameter int MW            = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_empty_i,
  input  logic [MW-1:0]               in_data_i,
  output logic                        in_pop_o,
  input  logic                        out_full_i,
  output logic                        out_push_o,
  output logic signed [VEC_WIDTH-1:0] out_x_o,
  output logic signed [VEC_WIDTH-1:0] out_y_o,
  output logic signed [VEC_WIDTH-1:0] out_z_o,
  output logic                        clip_o
);
  import evr_pkg::*;

  localparam int N  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int VW = VEC_WIDTH;
  localparam int IW = VW + 2;
  localparam int PW = IW + CW + 1;
  localparam int LW = ZW + 1;
  localparam logic signed [PW-1:0] RND    = PW'(1) <<< 23;
  localparam logic signed [IW-1:0] SAT_HI = IW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [IW-1:0] SAT_LO = -SAT_HI - IW'(1);

  function automatic logic signed [IW-1:0] dot2(
    input logic signed [IW-1:0] a,
    input logic signed [CW-1:0] p,
    input logic signed [IW-1:0] b,
    input logic signed [CW-1:0] q
  );
    logic signed [PW-1:0] sum;
    sum = PW'(a) * PW'(p) + PW'(b) * PW'(q) + RND;
    return sum[IW+23:24];
  endfunction

  logic ce, take;

  // cordic levels, lane 0 yaw, lane 1 roll, lane 2 pitch
  logic signed [XW-1:0] lx [N+1][3];
  logic signed [XW-1:0] ly [N+1][3];
  logic signed [ZW-1:0] lz [N+1][3];
  logic                 lf [N+1][3];
  logic [3*VW-1:0]      cvec_q [N];
  logic [N-1:0]         cvld_q;

  assign take     = !in_empty_i;
  assign in_pop_o = ce && take;

  for (genvar l = 0; l < 3; l++) begin : g_lvl0
    assign lx[0][l] = CORDIC_GAIN;
    assign ly[0][l] = '0;
    assign lz[0][l] = in_data_i[(2-l)*LW+1 +: ZW];
    assign lf[0][l] = in_data_i[(2-l)*LW];
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    for (genvar l = 0; l < 3; l++) begin : g_lane
      evr_cordic_stage #(.IDX(k)) u_stage (
        .clk_i  (clk_i),
        .en_i   (ce),
        .x_i    (lx[k][l]),
        .y_i    (ly[k][l]),
        .z_i    (lz[k][l]),
        .flip_i (lf[k][l]),
        .x_o    (lx[k+1][l]),
        .y_o    (ly[k+1][l]),
        .z_o    (lz[k+1][l]),
        .flip_o (lf[k+1][l])
      );
    end
  end

  // post stage: sign fold and rounding to q24
  logic signed [CW-1:0] c_d [3];
  logic signed [CW-1:0] s_d [3];
  logic signed [CW-1:0] c_q [3];
  logic signed [CW-1:0] s_q [3];
  logic [3*VW-1:0]      pvec_q;

  for (genvar l = 0; l < 3; l++) begin : g_post
    logic signed [XW-1:0] xf, yf, tx, ty;
    always_comb begin
      xf = lf[N][l] ? -lx[N][l] : lx[N][l];
      yf = lf[N][l] ? -ly[N][l] : ly[N][l];
      tx = xf + XW'(32);
      ty = yf + XW'(32);
      c_d[l] = CW'(tx >>> 6);
      s_d[l] = CW'(ty >>> 6);
    end
  end

  // rotation stages
  logic signed [IW-1:0] px, py, pz;
  logic signed [IW-1:0] r1x_q, r1y_q, r1z_q, r2x_q, r2y_q, r2z_q, r3x_q, r3y_q, r3z_q;
  logic signed [CW-1:0] r1c_q [2];
  logic signed [CW-1:0] r1s_q [2];
  logic signed [CW-1:0] r2c_q, r2s_q;
  logic signed [IW-1:0] r1x_d, r1y_d, r2x_d, r2z_d, r3y_d, r3z_d;
  logic signed [VW-1:0] sx_d, sy_d, sz_d;
  logic                 clip_d;
  logic                 post_vld_q, r1_vld_q, r2_vld_q, r3_vld_q, sat_vld_q;

  assign px = IW'(signed'(pvec_q[3*VW-1 -: VW]));
  assign py = IW'(signed'(pvec_q[2*VW-1 -: VW]));
  assign pz = IW'(signed'(pvec_q[VW-1:0]));

  always_comb begin
    r1x_d = dot2(px, c_q[0], py, -s_q[0]);
    r1y_d = dot2(px, s_q[0], py, c_q[0]);
    r2x_d = dot2(r1x_q, r1c_q[0], r1z_q, r1s_q[0]);
    r2z_d = dot2(r1x_q, -r1s_q[0], r1z_q, r1c_q[0]);
    r3y_d = dot2(r2y_q, r2c_q, r2z_q, -r2s_q);
    r3z_d = dot2(r2y_q, r2s_q, r2z_q, r2c_q);
    clip_d = 1'b0;
    sx_d = VW'(r3x_q);
    sy_d = VW'(r3y_q);
    sz_d = VW'(r3z_q);
    if (r3x_q > SAT_HI) begin
      sx_d = VW'(SAT_HI); clip_d = 1'b1;
    end else if (r3x_q < SAT_LO) begin
      sx_d = VW'(SAT_LO); clip_d = 1'b1;
    end
    if (r3y_q > SAT_HI) begin
      sy_d = VW'(SAT_HI); clip_d = 1'b1;
    end else if (r3y_q < SAT_LO) begin
      sy_d = VW'(SAT_LO); clip_d = 1'b1;
    end
    if (r3z_q > SAT_HI) begin
      sz_d = VW'(SAT_HI); clip_d = 1'b1;
    end else if (r3z_q < SAT_LO) begin
      sz_d = VW'(SAT_LO); clip_d = 1'b1;
    end
  end

  // whole back end advances together; only a full result queue holds it
  assign ce         = !sat_vld_q || !out_full_i;
  assign out_push_o = sat_vld_q && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q     <= '0;
      post_vld_q <= 1'b0;
      r1_vld_q   <= 1'b0;
      r2_vld_q   <= 1'b0;
      r3_vld_q   <= 1'b0;
      sat_vld_q  <= 1'b0;
    end else if (ce) begin
      cvld_q     <= {cvld_q[N-2:0], take};
      post_vld_q <= cvld_q[N-1];
      r1_vld_q   <= post_vld_q;
      r2_vld_q   <= r1_vld_q;
      r3_vld_q   <= r2_vld_q;
      sat_vld_q  <= r3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      cvec_q[0] <= in_data_i[MW-1 -: 3*VW];
      for (int k = 1; k < N; k++) begin
        cvec_q[k] <= cvec_q[k-1];
      end
      pvec_q <= cvec_q[N-1];
      for (int l = 0; l < 3; l++) begin
        c_q[l] <= c_d[l];
        s_q[l] <= s_d[l];
      end
      r1x_q    <= r1x_d;
      r1y_q    <= r1y_d;
      r1z_q    <= pz;
      r1c_q[0] <= c_q[1];
      r1s_q[0] <= s_q[1];
      r1c_q[1] <= c_q[2];
      r1s_q[1] <= s_q[2];
      r2x_q    <= r2x_d;
      r2y_q    <= r1y_q;
      r2z_q    <= r2z_d;
      r2c_q    <= r1c_q[1];
      r2s_q    <= r1s_q[1];
      r3x_q    <= r2x_q;
      r3y_q    <= r3y_d;
      r3z_q    <= r3z_d;
      out_x_o  <= sx_d;
      out_y_o  <= sy_d;
      out_z_o  <= sz_d;
      clip_o   <= clip_d;
    end
  end

endmodule

@@ sv/euler_vector_rotation.sv @@
// top level of the euler vector rotator
// rotates a q.16 velocity vector by Rx(pitch)*Ry(roll)*Rz(yaw) (angles negated
// when func is set, same product order), with sine and cosine from three
// pipelined cordic lanes; components saturate and clipped flags it. one request
// is taken every cycle while the back end is not stalled; a request passes the
// input queue, the cordic stages (capped at 24), one rounding stage, three
// rotation stages, one saturation stage and the result queue in that order
// (the back end takes a request off the input queue at the same edge
// that runs the first cordic stage). the back end pipeline only stalls when a
// finished result waits and the two-entry result queue is full
module euler_vector_rotation #(
  parameter int VEC_WIDTH     = evr_pkg::VEC_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = evr_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = evr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_x_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_y_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_z_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VEC_WIDTH-1:0]   out_x_o,
  output logic signed [VEC_WIDTH-1:0]   out_y_o,
  output logic signed [VEC_WIDTH-1:0]   out_z_o,
  output logic                          clipped_o
);
  import evr_pkg::*;

  localparam int LW = ZW + 1;
  // input queue entry: vector, then yaw, roll, pitch angle lanes
  localparam int MW = 3 * VEC_WIDTH + 3 * LW;
  localparam int OW = 3 * VEC_WIDTH + 1;

  logic signed [ZW-1:0]        fz [3];
  logic                        ff [3];
  logic [MW-1:0]               mid_wdata, mid_rdata;
  logic                        mid_empty, mid_pop;
  logic                        res_full, res_push;
  logic signed [VEC_WIDTH-1:0] bx, by, bz;
  logic                        bclip;
  logic [OW-1:0]               res_rdata;

  // front: classify the angles into folded cordic start values
  evr_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .func_i  (func_i),
    .yaw_i   (yaw_angle_i),
    .roll_i  (roll_angle_i),
    .pitch_i (pitch_angle_i),
    .z_o     (fz),
    .flip_o  (ff)
  );

  assign mid_wdata = {vec_x_i, vec_y_i, vec_z_i,
                      fz[0], ff[0], fz[1], ff[1], fz[2], ff[2]};

  // queue that decouples the front from the back end
  evr_fifo #(.W(MW), .DEPTH(2)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (mid_wdata),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rdata)
  );

  // back end: cordic, rotations, saturation
  evr_back #(
    .VEC_WIDTH     (VEC_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES),
    .MW            (MW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (mid_empty),
    .in_data_i  (mid_rdata),
    .in_pop_o   (mid_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_x_o    (bx),
    .out_y_o    (by),
    .out_z_o    (bz),
    .clip_o     (bclip)
  );

  // result queue, head is shown on the result ports
  evr_fifo #(.W(OW), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  ({bx, by, bz, bclip}),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_rdata)
  );

  assign out_x_o   = res_rdata[OW-1 -: VEC_WIDTH];
  assign out_y_o   = res_rdata[2*VEC_WIDTH -: VEC_WIDTH];
  assign out_z_o   = res_rdata[VEC_WIDTH:1];
  assign clipped_o = res_rdata[0];

endmodule
